// ===== design/rmh_pkg.sv =====
`default_nettype none
package rmh_pkg;
	localparam int MAX_SAMPLES_DEF = 1024;
	localparam int SAMPLE_BITS_DEF = 16;
	localparam int SMP_W = 16;
	localparam int MED_W = 17;
	localparam int CNT_W = 11;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_PUSH_CHK,
		ST_PUSH_CMP,
		ST_BAL,
		ST_POP_START,
		ST_POP_LAST,
		ST_POP_CHK,
		ST_POP_C1,
		ST_POP_C2,
		ST_OUT
	} state_t;
endpackage
`default_nettype wire

// ===== design/rmh_stream_if.sv =====
`default_nettype none
interface rmh_stream_if #(parameter int W = 1);
	logic         valid;
	logic         ready;
	logic [W-1:0] data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

// ===== design/running_median_two_heaps_unit.sv =====
// Dropped words go straight to the result; others sift up (PUSH_CHK, PUSH_CMP
// per level). On imbalance a top is popped by a sift-down (POP_CHK, POP_C1,
// POP_C2 per level; one-port read-modify-write), and pushed to the other heap.
// Throughput: one word at a time; the next word is taken the cycle after the
// result is accepted. Reset (arst_n low) empties both heaps; memories kept.
`default_nettype none
module running_median_two_heaps_unit #(
	parameter int MAX_SAMPLES = rmh_pkg::MAX_SAMPLES_DEF,
	parameter int SAMPLE_BITS = rmh_pkg::SAMPLE_BITS_DEF
) (
	input  wire logic clk,
	input  wire logic arst_n,
	rmh_stream_if.sink   in_ch,
	rmh_stream_if.source out_ch
);
	localparam int DEPTH = (MAX_SAMPLES + 1) / 2 + 1;
	localparam int IW = $clog2(DEPTH);
	localparam int CNW = $clog2(DEPTH + 1);
	localparam int XW = CNW + 1;
	localparam int NW = $clog2(MAX_SAMPLES + 1);
	localparam int SW = rmh_pkg::SMP_W;
	localparam int MW = rmh_pkg::MED_W;
	localparam int CW = rmh_pkg::CNT_W;

	// lower half: max-heap, upper half: min-heap
	logic signed [SAMPLE_BITS-1:0] lower_mem [DEPTH];
	logic signed [SAMPLE_BITS-1:0] upper_mem [DEPTH];
	logic signed [SAMPLE_BITS-1:0] lower_rd_s1, upper_rd_s1;

	rmh_pkg::state_t st_q, st_d;
	logic [CNW-1:0] lcnt_q, ucnt_q, pcnt_q;
	logic [IW-1:0]  idx_q;
	logic           bank_q, rebal_q, drop_q, out_v_q;
	logic signed [SAMPLE_BITS-1:0] key_q, mv_q, last_q, child_q, ltop_q, utop_q;
	logic [MW+CW:0] out_q;

	logic          acc, restart, full;
	logic signed [SAMPLE_BITS-1:0] smp, rd, best;
	logic signed [SAMPLE_BITS:0] smp2, lext, uext, med;
	logic [NW-1:0] tot;
	logic [XW-1:0] c_w, c_n;
	logic [IW-1:0] par;
	logic          push_up, leaf, take_r, go_down, bal_lu, bal_ul, pop_done;
	logic          we;
	logic [IW-1:0] waddr, raddr;
	logic signed [SAMPLE_BITS-1:0] wdata;

	function automatic logic better(logic upper, logic signed [SAMPLE_BITS-1:0] a,
			logic signed [SAMPLE_BITS-1:0] b);
		return upper ? (a < b) : (a > b);
	endfunction

	assign acc     = in_ch.valid && in_ch.ready;
	assign restart = in_ch.data[0];
	assign smp     = SAMPLE_BITS'(in_ch.data[SW:1]);
	assign smp2    = {smp, 1'b0};
	assign tot     = NW'(lcnt_q) + NW'(ucnt_q);
	assign full    = !restart && (tot >= NW'(MAX_SAMPLES));
	assign lext    = {ltop_q[SAMPLE_BITS-1], ltop_q};
	assign uext    = {utop_q[SAMPLE_BITS-1], utop_q};
	assign med     = (lcnt_q == '0) ? '0 : (lcnt_q > ucnt_q) ? lext + lext : lext + uext;

	assign rd      = bank_q ? upper_rd_s1 : lower_rd_s1;
	assign par     = (idx_q - IW'(1)) >> 1;
	assign push_up = better(bank_q, key_q, rd);
	assign c_w     = XW'({idx_q, 1'b1});
	assign c_n     = c_w + XW'(1);
	assign leaf    = c_w >= XW'(pcnt_q);
	assign take_r  = (c_n < XW'(pcnt_q)) && better(bank_q, rd, child_q);
	assign best    = take_r ? rd : child_q;
	assign go_down = better(bank_q, best, last_q);
	assign bal_lu  = XW'(lcnt_q) > XW'(ucnt_q) + XW'(1);
	assign bal_ul  = ucnt_q > lcnt_q;
	assign pop_done = (st_q == rmh_pkg::ST_POP_START && pcnt_q == '0) ||
		(st_q == rmh_pkg::ST_POP_CHK && leaf) ||
		(st_q == rmh_pkg::ST_POP_C2 && !go_down);

	assign in_ch.ready  = (st_q == rmh_pkg::ST_IDLE) && !out_v_q;
	assign out_ch.valid = out_v_q;
	assign out_ch.data  = out_q;

	always_ff @(posedge clk) begin
		if (we && !bank_q) lower_mem[waddr] <= wdata;
		if (we && bank_q) upper_mem[waddr] <= wdata;
		lower_rd_s1 <= lower_mem[raddr];
		upper_rd_s1 <= upper_mem[raddr];
	end

	// next state
	always_comb begin
		st_d = st_q;
		case (st_q)
			rmh_pkg::ST_IDLE: if (acc) begin
				st_d = full ? rmh_pkg::ST_OUT : rmh_pkg::ST_PUSH_CHK;
			end
			rmh_pkg::ST_PUSH_CHK: begin
				if (idx_q != '0) st_d = rmh_pkg::ST_PUSH_CMP;
				else st_d = rebal_q ? rmh_pkg::ST_OUT : rmh_pkg::ST_BAL;
			end
			rmh_pkg::ST_PUSH_CMP: begin
				if (push_up) st_d = rmh_pkg::ST_PUSH_CHK;
				else st_d = rebal_q ? rmh_pkg::ST_OUT : rmh_pkg::ST_BAL;
			end
			rmh_pkg::ST_BAL: st_d = (bal_lu || bal_ul) ? rmh_pkg::ST_POP_START : rmh_pkg::ST_OUT;
			rmh_pkg::ST_POP_START: st_d = pop_done ? rmh_pkg::ST_PUSH_CHK : rmh_pkg::ST_POP_LAST;
			rmh_pkg::ST_POP_LAST:  st_d = rmh_pkg::ST_POP_CHK;
			rmh_pkg::ST_POP_CHK:   st_d = pop_done ? rmh_pkg::ST_PUSH_CHK : rmh_pkg::ST_POP_C1;
			rmh_pkg::ST_POP_C1:    st_d = rmh_pkg::ST_POP_C2;
			rmh_pkg::ST_POP_C2:    st_d = pop_done ? rmh_pkg::ST_PUSH_CHK : rmh_pkg::ST_POP_CHK;
			rmh_pkg::ST_OUT:       st_d = rmh_pkg::ST_IDLE;
			default:               st_d = rmh_pkg::ST_IDLE;
		endcase
	end

	// memory port: one access per cycle
	always_comb begin
		we = 1'b0;
		waddr = idx_q;
		wdata = key_q;
		raddr = '0;
		case (st_q)
			rmh_pkg::ST_PUSH_CHK: begin
				if (idx_q == '0) we = 1'b1;
				else raddr = par;
			end
			rmh_pkg::ST_PUSH_CMP: begin
				we = 1'b1;
				if (push_up) wdata = rd;
			end
			rmh_pkg::ST_POP_START: raddr = IW'(pcnt_q);
			rmh_pkg::ST_POP_CHK: begin
				if (leaf) begin
					we = 1'b1;
					wdata = last_q;
				end else begin
					raddr = IW'(c_w);
				end
			end
			rmh_pkg::ST_POP_C1: raddr = IW'(c_n);
			rmh_pkg::ST_POP_C2: begin
				we = 1'b1;
				wdata = go_down ? best : last_q;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= rmh_pkg::ST_IDLE;
			lcnt_q <= '0;
			ucnt_q <= '0;
			pcnt_q <= '0;
			idx_q <= '0;
			bank_q <= 1'b0;
			rebal_q <= 1'b0;
			drop_q <= 1'b0;
			out_v_q <= 1'b0;
			key_q <= '0;
			mv_q <= '0;
			last_q <= '0;
			child_q <= '0;
			ltop_q <= '0;
			utop_q <= '0;
			out_q <= '0;
		end else begin
			st_q <= st_d;
			// tops mirror entry 0 of each heap
			if (we && waddr == '0) begin
				if (bank_q) utop_q <= wdata;
				else ltop_q <= wdata;
			end
			if (out_ch.valid && out_ch.ready) out_v_q <= 1'b0;
			case (st_q)
				rmh_pkg::ST_IDLE: if (acc) begin
					rebal_q <= 1'b0;
					drop_q <= full;
					if (!full) begin
						key_q <= smp;
						if (restart || tot == '0 || smp2 <= med) begin
							bank_q <= 1'b0;
							idx_q <= restart ? '0 : IW'(lcnt_q);
							lcnt_q <= restart ? CNW'(1) : lcnt_q + CNW'(1);
							if (restart) ucnt_q <= '0;
						end else begin
							bank_q <= 1'b1;
							idx_q <= IW'(ucnt_q);
							ucnt_q <= ucnt_q + CNW'(1);
						end
					end
				end
				rmh_pkg::ST_PUSH_CMP: if (push_up) idx_q <= par;
				rmh_pkg::ST_BAL: begin
					idx_q <= '0;
					if (bal_lu) begin
						bank_q <= 1'b0;
						mv_q <= ltop_q;
						lcnt_q <= lcnt_q - CNW'(1);
						pcnt_q <= lcnt_q - CNW'(1);
					end else if (bal_ul) begin
						bank_q <= 1'b1;
						mv_q <= utop_q;
						ucnt_q <= ucnt_q - CNW'(1);
						pcnt_q <= ucnt_q - CNW'(1);
					end
				end
				rmh_pkg::ST_POP_LAST: last_q <= rd;
				rmh_pkg::ST_POP_C1:   child_q <= rd;
				rmh_pkg::ST_POP_C2:   if (go_down) idx_q <= take_r ? IW'(c_n) : IW'(c_w);
				rmh_pkg::ST_OUT: begin
					out_q <= {MW'(med), CW'(tot), drop_q};
					out_v_q <= 1'b1;
				end
				default: ;
			endcase
			// moved top goes into the other heap
			if (pop_done) begin
				bank_q <= !bank_q;
				key_q <= mv_q;
				rebal_q <= 1'b1;
				if (bank_q) begin
					idx_q <= IW'(lcnt_q);
					lcnt_q <= lcnt_q + CNW'(1);
				end else begin
					idx_q <= IW'(ucnt_q);
					ucnt_q <= ucnt_q + CNW'(1);
				end
			end
		end
	end

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_ch.valid && !out_ch.ready |=> out_ch.valid && $stable(out_ch.data));
	a_ready_idle: assert property (@(posedge clk) disable iff (!arst_n)
		in_ch.ready |-> st_q == rmh_pkg::ST_IDLE && !out_ch.valid);
	a_balance: assert property (@(posedge clk) disable iff (!arst_n)
		st_q == rmh_pkg::ST_IDLE |-> lcnt_q == ucnt_q || lcnt_q == ucnt_q + CNW'(1));
	a_total: assert property (@(posedge clk) disable iff (!arst_n)
		tot <= NW'(MAX_SAMPLES));
endmodule
`default_nettype wire
